@@ rtl/sva_pkg.sv @@
package sva_pkg;

    // Input item: one target/source pair.
    typedef struct packed {
        logic        [30:0] target_x;
        logic        [30:0] target_y;
        logic        [30:0] source_x;
        logic        [30:0] source_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               last_source;
    } sva_in_t;

    // Result item: the accumulated target velocity.
    typedef struct packed {
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
    } sva_out_t;

    // Operations of the shared serial arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL_RAW,
        OP_MUL_Q,
        OP_DIV_Q,
        OP_SQRT
    } sva_op_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic        start;
        sva_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } sva_req_t;

    // Response from the arithmetic unit.
    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } sva_rsp_t;

    // Sequencer steps.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_EP,
        ST_ROOT,
        ST_CONV,
        ST_SUMS,
        ST_NORM,
        ST_LN_SQ,
        ST_LN_MUL,
        ST_T1_A,
        ST_T1_B,
        ST_T1_C,
        ST_T2_A,
        ST_T2_B,
        ST_T2_C,
        ST_TR1,
        ST_TR2_A,
        ST_FDX,
        ST_FDY,
        ST_TR2_B,
        ST_VX_A,
        ST_VX_B,
        ST_ACC_X,
        ST_VY_A,
        ST_VY_B,
        ST_ACC_Y,
        ST_FIN
    } sva_state_t;

    localparam logic [30:0] EPS_RESET  = 31'd5368709;
    localparam logic [63:0] LN2_Q62    = 64'h2C5C85FDF473DE6B;
    localparam logic [63:0] INV4PI_Q62 = 64'h0517CC1B727220A9;
    localparam logic [63:0] S64_MAX    = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] S64_MIN    = 64'h8000000000000000;

endpackage

@@ rtl/sva_arith.sv @@
module sva_arith #(
    parameter int FRAC_BITS = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sva_pkg::sva_req_t req,
    output sva_pkg::sva_rsp_t rsp
);

    localparam int HSH = 64 - FRAC_BITS;

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    sva_pkg::sva_op_t  op_reg, op_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [128:0]      acc_reg, acc_next;
    logic [63:0]       rem_reg, rem_next;
    logic [63:0]       quo_reg, quo_next;
    logic [63:0]       dvs_reg, dvs_next;
    logic              sat_reg, sat_next;
    logic              neg_reg, neg_next;

    logic [63:0]       ua, ub;
    logic [64:0]       hi_sum;
    logic [64:0]       r2;
    logic [63:0]       sq_try;
    logic              last_iter;
    logic              mq_sat;
    logic [63:0]       mq_mag;
    logic [63:0]       result;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    assign ua     = mag64(req.a);
    assign ub     = mag64(req.b);
    assign hi_sum = acc_reg[128:64] + (acc_reg[0] ? {1'b0, dvs_reg} : 65'd0);
    assign r2     = {rem_reg, quo_reg[63]};
    assign sq_try = quo_reg + dvs_reg;
    assign last_iter = (op_reg == sva_pkg::OP_SQRT) ? (cnt_reg == 6'd31) : (cnt_reg == 6'd63);

    // One bit of product, quotient or root per cycle.
    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        sat_next  = sat_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = 6'd0;
            unique case (req.op)
                sva_pkg::OP_MUL_RAW, sva_pkg::OP_MUL_Q: begin
                    acc_next = {65'd0, ub};
                    dvs_next = ua;
                    neg_next = req.a[63] ^ req.b[63];
                end
                sva_pkg::OP_DIV_Q: begin
                    rem_next = ua >> HSH;
                    quo_next = ua << FRAC_BITS;
                    dvs_next = req.b;
                    sat_next = (ua >> HSH) >= req.b;
                    neg_next = req.a[63];
                end
                sva_pkg::OP_SQRT: begin
                    rem_next = req.a;
                    quo_next = 64'd0;
                    dvs_next = 64'd1 << 62;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            unique case (op_reg)
                sva_pkg::OP_MUL_RAW, sva_pkg::OP_MUL_Q: begin
                    acc_next = {1'b0, hi_sum, acc_reg[63:1]};
                end
                sva_pkg::OP_DIV_Q: begin
                    if (r2 >= {1'b0, dvs_reg}) begin
                        rem_next = 64'(r2 - {1'b0, dvs_reg});
                        quo_next = {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_next = r2[63:0];
                        quo_next = {quo_reg[62:0], 1'b0};
                    end
                end
                sva_pkg::OP_SQRT: begin
                    if (rem_reg >= sq_try) begin
                        rem_next = rem_reg - sq_try;
                        quo_next = (quo_reg >> 1) + dvs_reg;
                    end else begin
                        quo_next = quo_reg >> 1;
                    end
                    dvs_next = dvs_reg >> 2;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
            if (last_iter) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        sat_reg <= sat_next;
        neg_reg <= neg_next;
    end

    // Scaling, sign and saturation of the finished value.
    assign mq_sat = |acc_reg[127:63+FRAC_BITS];
    assign mq_mag = {1'b0, acc_reg[62+FRAC_BITS:FRAC_BITS]};

    always_comb begin
        unique case (op_reg)
            sva_pkg::OP_MUL_RAW: result = acc_reg[63:0];
            sva_pkg::OP_MUL_Q: begin
                if (mq_sat) begin
                    result = neg_reg ? sva_pkg::S64_MIN : sva_pkg::S64_MAX;
                end else begin
                    result = neg_reg ? (~mq_mag + 64'd1) : mq_mag;
                end
            end
            sva_pkg::OP_DIV_Q: begin
                if (sat_reg || quo_reg[63]) begin
                    result = neg_reg ? sva_pkg::S64_MIN : sva_pkg::S64_MAX;
                end else begin
                    result = neg_reg ? (~quo_reg + 64'd1) : quo_reg;
                end
            end
            sva_pkg::OP_SQRT: result = quo_reg;
            default: result = 64'd0;
        endcase
    end

    assign rsp.done   = fin_reg;
    assign rsp.result = result;

endmodule

@@ rtl/stokeslet_velocity_accumulator_top.sv @@
// Channel   Ports                          Carries
// input     s_valid, s_ready, s_data       one target/source pair
// result    m_valid, m_ready, m_data       target velocity, after the last source
// config    epsilon_wr_en, epsilon_wr_data blob size, no read-back
//
// Each pair takes three squares, the root, the normalizing shifts of sq + eps for the
// logarithm, FRAC_BITS log squarings, 11 products and 5 quotients.
// Reset clears the accumulators and restores epsilon to 0.005.
// A waiting result does not block the next pair; only a second result stalls in the
// final step until the first one is taken.
module stokeslet_velocity_accumulator_top #(
    parameter int FRAC_BITS = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              epsilon_wr_en,
    input  logic [30:0]       epsilon_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  sva_pkg::sva_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sva_pkg::sva_out_t m_data
);

    localparam int SHL = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int SHR = (FRAC_BITS >= 30) ? 0 : 30 - FRAC_BITS;
    localparam int IW  = $clog2(FRAC_BITS);
    localparam logic [63:0] LN2_Q = sva_pkg::LN2_Q62 >> (62 - FRAC_BITS);
    localparam logic [63:0] K_Q   = sva_pkg::INV4PI_Q62 >> (62 - FRAC_BITS);

    sva_pkg::sva_state_t state_reg, state_next;
    logic                run_reg, run_next;
    logic [30:0]         eps_reg;
    logic                last_reg;
    logic signed [63:0]  dx_reg, dy_reg, fx_reg, fy_reg;
    logic [63:0]         sum_reg;
    logic signed [63:0]  ep_reg, sq_reg, d_reg, s2_reg;
    logic [63:0]         w_reg;
    logic [5:0]          p_reg;
    logic [63:0]         mt_reg;
    logic [FRAC_BITS-1:0] y_reg;
    logic [IW-1:0]       i_reg;
    logic signed [63:0]  ln_reg, a_reg, b_reg, t1_reg;
    logic signed [63:0]  acc_x_reg, acc_y_reg;
    logic                m_valid_reg;
    sva_pkg::sva_out_t   m_data_reg;

    sva_pkg::sva_req_t   req;
    sva_pkg::sva_rsp_t   rsp;
    logic                unit_step;
    logic                done;
    logic                out_free;
    logic                norm_shift;
    logic [63:0]         e30, adx, ady, res;
    logic signed [31:0]  dx30, dy30;
    logic signed [63:0]  log2v, ep_cv, sq_cv;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? sva_pkg::S64_MIN : sva_pkg::S64_MAX;
        end
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            return a[63] ? sva_pkg::S64_MIN : sva_pkg::S64_MAX;
        end
        return s;
    endfunction

    // Move a Q.30 value to Q.FRAC_BITS, flooring when bits are dropped.
    function automatic logic signed [63:0] to_q(input logic signed [63:0] v);
        return (v <<< SHL) >>> SHR;
    endfunction

    sva_arith #(
        .FRAC_BITS(FRAC_BITS)
    ) u_arith (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rsp    (rsp)
    );

    assign done     = rsp.done;
    assign res      = rsp.result;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == sva_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign e30  = {33'd0, (eps_reg == 31'd0) ? 31'd1 : eps_reg};
    assign dx30 = $signed({1'b0, s_data.target_x}) - $signed({1'b0, s_data.source_x});
    assign dy30 = $signed({1'b0, s_data.target_y}) - $signed({1'b0, s_data.source_y});
    assign adx  = dx_reg[63] ? 64'(-dx_reg) : 64'(dx_reg);
    assign ady  = dy_reg[63] ? 64'(-dy_reg) : 64'(dy_reg);
    assign ep_cv = to_q($signed(e30));
    assign sq_cv = to_q(sq_reg);
    assign log2v = ((64'($signed({1'b0, p_reg})) - 64'(FRAC_BITS)) <<< FRAC_BITS)
                 | $signed(64'(y_reg));
    assign norm_shift = (p_reg != 6'd0) && !w_reg[62];

    // Operands and operation for each step that uses the arithmetic unit.
    always_comb begin
        unit_step = 1'b1;
        req.op    = sva_pkg::OP_MUL_Q;
        req.a     = 64'd0;
        req.b     = 64'd0;
        unique case (state_reg)
            sva_pkg::ST_SQ_DX: begin req.op = sva_pkg::OP_MUL_RAW; req.a = adx; req.b = adx; end
            sva_pkg::ST_SQ_DY: begin req.op = sva_pkg::OP_MUL_RAW; req.a = ady; req.b = ady; end
            sva_pkg::ST_SQ_EP: begin req.op = sva_pkg::OP_MUL_RAW; req.a = e30; req.b = e30; end
            sva_pkg::ST_ROOT:  begin req.op = sva_pkg::OP_SQRT; req.a = sum_reg; end
            sva_pkg::ST_LN_SQ:  begin req.a = mt_reg; req.b = mt_reg; end
            sva_pkg::ST_LN_MUL: begin req.a = log2v; req.b = LN2_Q; end
            sva_pkg::ST_T1_A:   begin req.a = ep_reg; req.b = s2_reg; end
            sva_pkg::ST_T1_B:   begin req.op = sva_pkg::OP_DIV_Q; req.a = a_reg; req.b = d_reg; end
            sva_pkg::ST_T1_C:   begin req.op = sva_pkg::OP_DIV_Q; req.a = a_reg; req.b = sq_reg; end
            sva_pkg::ST_T2_A:   begin req.op = sva_pkg::OP_DIV_Q; req.a = s2_reg; req.b = d_reg; end
            sva_pkg::ST_T2_B:   begin req.op = sva_pkg::OP_DIV_Q; req.a = b_reg; req.b = d_reg; end
            sva_pkg::ST_T2_C:   begin req.op = sva_pkg::OP_DIV_Q; req.a = b_reg; req.b = sq_reg; end
            sva_pkg::ST_TR1:    begin req.a = t1_reg; req.b = K_Q; end
            sva_pkg::ST_TR2_A:  begin req.a = b_reg; req.b = K_Q; end
            sva_pkg::ST_FDX:    begin req.a = fx_reg; req.b = dx_reg; end
            sva_pkg::ST_FDY:    begin req.a = fy_reg; req.b = dy_reg; end
            sva_pkg::ST_TR2_B:  begin req.a = b_reg; req.b = a_reg; end
            sva_pkg::ST_VX_A:   begin req.a = b_reg; req.b = dx_reg; end
            sva_pkg::ST_VX_B:   begin req.a = fx_reg; req.b = t1_reg; end
            sva_pkg::ST_VY_A:   begin req.a = b_reg; req.b = dy_reg; end
            sva_pkg::ST_VY_B:   begin req.a = fy_reg; req.b = t1_reg; end
            default:            unit_step = 1'b0;
        endcase
        req.start = unit_step && !run_reg;
    end

    // Step sequencing.
    always_comb begin
        state_next = state_reg;
        run_next   = run_reg;
        if (unit_step) begin
            if (!run_reg) begin
                run_next = 1'b1;
            end
            if (done) begin
                run_next = 1'b0;
            end
        end
        unique case (state_reg)
            sva_pkg::ST_IDLE:  if (s_valid) state_next = sva_pkg::ST_SQ_DX;
            sva_pkg::ST_SQ_DX: if (done) state_next = sva_pkg::ST_SQ_DY;
            sva_pkg::ST_SQ_DY: if (done) state_next = sva_pkg::ST_SQ_EP;
            sva_pkg::ST_SQ_EP: if (done) state_next = sva_pkg::ST_ROOT;
            sva_pkg::ST_ROOT:  if (done) state_next = sva_pkg::ST_CONV;
            sva_pkg::ST_CONV:  state_next = sva_pkg::ST_SUMS;
            sva_pkg::ST_SUMS:  state_next = sva_pkg::ST_NORM;
            sva_pkg::ST_NORM:  if (!norm_shift) state_next = sva_pkg::ST_LN_SQ;
            sva_pkg::ST_LN_SQ: begin
                if (done && i_reg == IW'(FRAC_BITS - 1)) state_next = sva_pkg::ST_LN_MUL;
            end
            sva_pkg::ST_LN_MUL: if (done) state_next = sva_pkg::ST_T1_A;
            sva_pkg::ST_T1_A:   if (done) state_next = sva_pkg::ST_T1_B;
            sva_pkg::ST_T1_B:   if (done) state_next = sva_pkg::ST_T1_C;
            sva_pkg::ST_T1_C:   if (done) state_next = sva_pkg::ST_T2_A;
            sva_pkg::ST_T2_A:   if (done) state_next = sva_pkg::ST_T2_B;
            sva_pkg::ST_T2_B:   if (done) state_next = sva_pkg::ST_T2_C;
            sva_pkg::ST_T2_C:   if (done) state_next = sva_pkg::ST_TR1;
            sva_pkg::ST_TR1:    if (done) state_next = sva_pkg::ST_TR2_A;
            sva_pkg::ST_TR2_A:  if (done) state_next = sva_pkg::ST_FDX;
            sva_pkg::ST_FDX:    if (done) state_next = sva_pkg::ST_FDY;
            sva_pkg::ST_FDY:    if (done) state_next = sva_pkg::ST_TR2_B;
            sva_pkg::ST_TR2_B:  if (done) state_next = sva_pkg::ST_VX_A;
            sva_pkg::ST_VX_A:   if (done) state_next = sva_pkg::ST_VX_B;
            sva_pkg::ST_VX_B:   if (done) state_next = sva_pkg::ST_ACC_X;
            sva_pkg::ST_ACC_X:  state_next = sva_pkg::ST_VY_A;
            sva_pkg::ST_VY_A:   if (done) state_next = sva_pkg::ST_VY_B;
            sva_pkg::ST_VY_B:   if (done) state_next = sva_pkg::ST_ACC_Y;
            sva_pkg::ST_ACC_Y:  state_next = sva_pkg::ST_FIN;
            sva_pkg::ST_FIN:    if (!last_reg || out_free) state_next = sva_pkg::ST_IDLE;
            default:            state_next = sva_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sva_pkg::ST_IDLE;
            run_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

    // Blob size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= sva_pkg::EPS_RESET;
        end else if (epsilon_wr_en) begin
            eps_reg <= epsilon_wr_data;
        end
    end

    // Working registers, written as each step finishes.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            sva_pkg::ST_IDLE: begin
                if (s_valid) begin
                    dx_reg   <= 64'(dx30);
                    dy_reg   <= 64'(dy30);
                    fx_reg   <= 64'(s_data.force_x);
                    fy_reg   <= 64'(s_data.force_y);
                    last_reg <= s_data.last_source;
                end
            end
            sva_pkg::ST_SQ_DX: if (done) sum_reg <= res;
            sva_pkg::ST_SQ_DY: if (done) sum_reg <= sum_reg + res;
            sva_pkg::ST_SQ_EP: if (done) sum_reg <= sum_reg + res;
            sva_pkg::ST_ROOT:  if (done) sq_reg <= $signed(res);
            sva_pkg::ST_CONV: begin
                dx_reg <= to_q(dx_reg);
                dy_reg <= to_q(dy_reg);
                fx_reg <= to_q(fx_reg);
                fy_reg <= to_q(fy_reg);
                ep_reg <= (ep_cv == 64'sd0) ? 64'sd1 : ep_cv;
                sq_reg <= (sq_cv == 64'sd0) ? 64'sd1 : sq_cv;
            end
            sva_pkg::ST_SUMS: begin
                d_reg  <= sq_reg + ep_reg;
                s2_reg <= sq_reg + (ep_reg <<< 1);
                w_reg  <= 64'(sq_reg + ep_reg);
                p_reg  <= 6'd62;
            end
            sva_pkg::ST_NORM: begin
                if (norm_shift) begin
                    w_reg <= w_reg << 1;
                    p_reg <= p_reg - 6'd1;
                end else begin
                    mt_reg <= w_reg >> (62 - FRAC_BITS);
                    y_reg  <= '0;
                    i_reg  <= '0;
                end
            end
            sva_pkg::ST_LN_SQ: begin
                if (done) begin
                    if (|res[63:FRAC_BITS+1]) begin
                        mt_reg <= res >> 1;
                        y_reg  <= {y_reg[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        mt_reg <= res;
                        y_reg  <= {y_reg[FRAC_BITS-2:0], 1'b0};
                    end
                    i_reg <= i_reg + IW'(1);
                end
            end
            sva_pkg::ST_LN_MUL: if (done) ln_reg <= $signed(res);
            sva_pkg::ST_T1_A:   if (done) a_reg <= $signed(res);
            sva_pkg::ST_T1_B:   if (done) a_reg <= $signed(res);
            sva_pkg::ST_T1_C:   if (done) t1_reg <= sat_sub(ln_reg, $signed(res));
            sva_pkg::ST_T2_A:   if (done) b_reg <= $signed(res);
            sva_pkg::ST_T2_B:   if (done) b_reg <= $signed(res);
            sva_pkg::ST_T2_C:   if (done) b_reg <= $signed(res);
            sva_pkg::ST_TR1:    if (done) t1_reg <= $signed(res);
            sva_pkg::ST_TR2_A:  if (done) b_reg <= $signed(res);
            sva_pkg::ST_FDX:    if (done) a_reg <= $signed(res);
            sva_pkg::ST_FDY:    if (done) a_reg <= sat_add(a_reg, $signed(res));
            sva_pkg::ST_TR2_B:  if (done) b_reg <= $signed(res);
            sva_pkg::ST_VX_A:   if (done) a_reg <= $signed(res);
            sva_pkg::ST_VX_B:   if (done) a_reg <= sat_sub(a_reg, $signed(res));
            sva_pkg::ST_VY_A:   if (done) a_reg <= $signed(res);
            sva_pkg::ST_VY_B:   if (done) a_reg <= sat_sub(a_reg, $signed(res));
            default: begin
            end
        endcase
    end

    // Accumulators and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == sva_pkg::ST_ACC_X) begin
                acc_x_reg <= sat_add(acc_x_reg, a_reg);
            end
            if (state_reg == sva_pkg::ST_ACC_Y) begin
                acc_y_reg <= sat_add(acc_y_reg, a_reg);
            end
            if (state_reg == sva_pkg::ST_FIN && last_reg && out_free) begin
                m_valid_reg      <= 1'b1;
                m_data_reg.vel_x <= acc_x_reg;
                m_data_reg.vel_y <= acc_y_reg;
                acc_x_reg        <= '0;
                acc_y_reg        <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    // Only one pair is in work at a time.
    a_one_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pair accepted while another is in work");

    // A result appears only from the final step.
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == sva_pkg::ST_FIN) && $past(last_reg))
        else $error("result loaded outside the final step");

    // Emitting a result clears the accumulators.
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> acc_x_reg == 64'sd0 && acc_y_reg == 64'sd0)
        else $error("accumulators not cleared after result");

    // The arithmetic unit finishes only inside a step that started it.
    a_done_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> unit_step && run_reg)
        else $error("arithmetic unit finished outside its step");
`endif

endmodule
